// File: hdl/wqm_pkg.sv
// ----------------------------------------------------------------------------
// Write queue master package
// Shared constants, codes and types of the I2C write queue master.
// ----------------------------------------------------------------------------
package wqm_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned PtrW       = $clog2(QueueDepth);

  localparam logic [7:0] DeviceAddressReset = 8'h78;

  // Request kinds carried in tuser.
  localparam logic FuncEnqueue = 1'b0;
  localparam logic FuncEvent   = 1'b1;

  // Enqueue status codes.
  localparam logic [1:0] EnqNone    = 2'd0;
  localparam logic [1:0] EnqAccept  = 2'd1;
  localparam logic [1:0] EnqRefused = 2'd2;

  // Bus action codes.
  localparam logic [2:0] ActNone  = 3'd0;
  localparam logic [2:0] ActStart = 3'd1;
  localparam logic [2:0] ActAddr  = 3'd2;
  localparam logic [2:0] ActData  = 3'd3;
  localparam logic [2:0] ActStop  = 3'd4;

  // Queue status codes.
  localparam logic [1:0] QsIdle = 2'd0;
  localparam logic [1:0] QsBusy = 2'd1;
  localparam logic [1:0] QsFull = 2'd2;

  // Transfer sequencer states.
  typedef enum logic [2:0] {
    SEQ_IDLE = 3'b001,
    SEQ_ADDR = 3'b010,
    SEQ_DATA = 3'b100
  } seq_e;

  // One ring entry.
  typedef struct packed {
    logic [7:0] len;
    logic [7:0] tag;
  } desc_t;

  // One input request.
  typedef struct packed {
    logic       func;
    logic [7:0] buffer_tag;
    logic [7:0] transfer_length;
    logic       ack_missing;
    logic       write_collision;
  } item_t;

  // One result.
  typedef struct packed {
    logic [1:0] queue_status;
    logic [7:0] release_tag;
    logic       release_valid;
    logic [7:0] data_offset;
    logic [7:0] data_tag;
    logic [7:0] tx_address;
    logic [2:0] bus_action;
    logic [1:0] enqueue_status;
  } result_t;

  // Queue and sequencer state kept in registers.
  typedef struct packed {
    logic [PtrW-1:0] rp;
    logic [PtrW-1:0] wp;
    logic            empty;
    logic            full;
    seq_e            seq;
    logic [7:0]      remaining;
    logic [7:0]      tag;
    logic [7:0]      offset;
    logic            holding;
  } ctx_t;

  // Ring write request from the sequencer.
  typedef struct packed {
    logic            we;
    logic [PtrW-1:0] addr;
    desc_t           data;
  } ring_wr_t;

  // Ring pointer increment with wrap.
  function automatic logic [PtrW-1:0] advance(input logic [PtrW-1:0] p);
    advance = (p == PtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

// File: hdl/wqm_ring.sv
// ----------------------------------------------------------------------------
// Descriptor ring memory
// Synchronous memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module wqm_ring (
  input  logic                     clk_i,
  input  wqm_pkg::ring_wr_t        wr_i,
  input  logic                     re_i,
  input  logic [wqm_pkg::PtrW-1:0] raddr_i,
  output wqm_pkg::desc_t           rdata_o
);

  wqm_pkg::desc_t mem_q [wqm_pkg::QueueDepth];
  wqm_pkg::desc_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/wqm_seq.sv
// ----------------------------------------------------------------------------
// Queue and transfer sequencer step
// Computes the next queue state, the ring write and the result of a request.
// ----------------------------------------------------------------------------
module wqm_seq (
  input  wqm_pkg::ctx_t     ctx_i,
  input  wqm_pkg::item_t    item_i,
  input  wqm_pkg::desc_t    head_i,
  input  logic [7:0]        dev_addr_i,
  output wqm_pkg::ctx_t     ctx_o,
  output wqm_pkg::ring_wr_t wr_o,
  output wqm_pkg::result_t  res_o
);

  always_comb begin
    wqm_pkg::ctx_t    c;
    wqm_pkg::result_t r;
    wqm_pkg::desc_t   head;
    logic             run;
    logic             ack_missing;

    c           = ctx_i;
    r           = '0;
    wr_o        = '0;
    run         = 1'b0;
    ack_missing = 1'b0;
    // The ring read is stale when the queue was empty; then the head is the
    // descriptor being written by this very request.
    head        = ctx_i.empty ? wqm_pkg::desc_t'{len: item_i.transfer_length,
                                                 tag: item_i.buffer_tag}
                              : head_i;

    // Enqueue or event dispatch.
    if (item_i.func == wqm_pkg::FuncEnqueue) begin
      if (ctx_i.full) begin
        r.enqueue_status = wqm_pkg::EnqRefused;
      end else begin
        wr_o.we       = 1'b1;
        wr_o.addr     = ctx_i.wp;
        wr_o.data.tag = item_i.buffer_tag;
        wr_o.data.len = item_i.transfer_length;
        c.wp          = wqm_pkg::advance(ctx_i.wp);
        c.empty       = 1'b0;
        c.full        = (c.wp == ctx_i.rp);
        r.enqueue_status = wqm_pkg::EnqAccept;
        run           = (ctx_i.seq == wqm_pkg::SEQ_IDLE);
      end
    end else begin
      // A collision drops the transfer and acts as an idle event.
      if (item_i.write_collision) begin
        c.seq = wqm_pkg::SEQ_IDLE;
      end
      run         = 1'b1;
      ack_missing = item_i.ack_missing;
    end

    // Sequencer step.
    if (run) begin
      case (c.seq)
        wqm_pkg::SEQ_IDLE: begin
          if (!c.empty) begin
            c.remaining  = head.len;
            c.tag        = head.tag;
            c.offset     = '0;
            c.holding    = 1'b1;
            c.rp         = wqm_pkg::advance(c.rp);
            c.full       = 1'b0;
            c.empty      = (c.rp == c.wp);
            r.bus_action = wqm_pkg::ActStart;
            c.seq        = wqm_pkg::SEQ_ADDR;
          end
        end
        wqm_pkg::SEQ_ADDR: begin
          r.bus_action = wqm_pkg::ActAddr;
          r.tx_address = dev_addr_i;
          c.seq        = wqm_pkg::SEQ_DATA;
        end
        wqm_pkg::SEQ_DATA: begin
          if (!ack_missing && (c.remaining != 8'd0)) begin
            r.bus_action  = wqm_pkg::ActData;
            r.data_tag    = c.tag;
            r.data_offset = c.offset;
            c.offset      = c.offset + 8'd1;
            c.remaining   = c.remaining - 8'd1;
          end else begin
            r.bus_action    = wqm_pkg::ActStop;
            r.release_valid = c.holding;
            r.release_tag   = c.holding ? c.tag : 8'd0;
            c.holding       = 1'b0;
            c.seq           = wqm_pkg::SEQ_IDLE;
          end
        end
        default: begin
          // An unknown sequencer code ends with a stop.
          r.bus_action    = wqm_pkg::ActStop;
          r.release_valid = c.holding;
          r.release_tag   = c.holding ? c.tag : 8'd0;
          c.holding       = 1'b0;
          c.seq           = wqm_pkg::SEQ_IDLE;
        end
      endcase
    end

    // Queue status after the step.
    if (c.full) begin
      r.queue_status = wqm_pkg::QsFull;
    end else if (c.empty && (c.seq == wqm_pkg::SEQ_IDLE)) begin
      r.queue_status = wqm_pkg::QsIdle;
    end else begin
      r.queue_status = wqm_pkg::QsBusy;
    end

    ctx_o = c;
    res_o = r;
  end

endmodule

// File: hdl/i2c_write_queue_master_unit.sv
// ----------------------------------------------------------------------------
// I2C write queue master
// Timing: a request is accepted and the ring head is read at the same edge;
// the result is computed in the execute state and registered once the output
// register is free or being drained, then offered on the result stream.
// Flow: a new request is taken only after the previous result has been
// registered, so a stalled result also holds off the next request.
// Reset: pointers, flags and sequencer clear at once; the ring is not cleared.
// ----------------------------------------------------------------------------
module i2c_write_queue_master_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: device address byte.
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // Requests in.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] buffer_tag, [15:8] transfer_length, [16] ack_missing,
  // [17] write_collision, [23:18] zero.
  input  logic [23:0] s_axis_tdata,
  // [0] func.
  input  logic        s_axis_tuser,
  // Results out.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] enqueue_status, [4:2] bus_action, [12:5] tx_address,
  // [20:13] data_tag, [28:21] data_offset, [29] release_valid,
  // [37:30] release_tag, [39:38] queue_status.
  output logic [39:0] m_axis_tdata
);

  typedef enum logic [1:0] {
    ST_IN = 2'b01,
    ST_EX = 2'b10
  } state_e;

  state_e            state_q, state_d;
  wqm_pkg::ctx_t     ctx_q, ctx_next;
  wqm_pkg::item_t    item_q;
  wqm_pkg::desc_t    head;
  wqm_pkg::ring_wr_t wr;
  wqm_pkg::ring_wr_t ring_wr;
  wqm_pkg::result_t  res;
  wqm_pkg::result_t  out_q;
  logic              out_valid_q;
  logic [7:0]        dev_addr_q;
  logic              in_fire;
  logic              ex_go;

  assign s_axis_tready = (state_q == ST_IN);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign ex_go         = (state_q == ST_EX) && (!out_valid_q || m_axis_tready);

  // Descriptor ring: head read at accept, write-back in the update cycle.
  assign ring_wr.we   = wr.we && ex_go;
  assign ring_wr.addr = wr.addr;
  assign ring_wr.data = wr.data;

  wqm_ring u_ring (
    .clk_i   (clk_i),
    .wr_i    (ring_wr),
    .re_i    (in_fire),
    .raddr_i (ctx_q.rp),
    .rdata_o (head)
  );

  wqm_seq u_seq (
    .ctx_i      (ctx_q),
    .item_i     (item_q),
    .head_i     (head),
    .dev_addr_i (dev_addr_q),
    .ctx_o      (ctx_next),
    .wr_o       (wr),
    .res_o      (res)
  );

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.func            <= s_axis_tuser;
      item_q.buffer_tag      <= s_axis_tdata[7:0];
      item_q.transfer_length <= s_axis_tdata[15:8];
      item_q.ack_missing     <= s_axis_tdata[16];
      item_q.write_collision <= s_axis_tdata[17];
    end
  end

  // Control sequencing.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IN: begin
        if (in_fire) begin
          state_d = ST_EX;
        end
      end
      ST_EX: begin
        if (ex_go) begin
          state_d = ST_IN;
        end
      end
      default: begin
        state_d = ST_IN;
      end
    endcase
  end

  // State, configuration and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IN;
      ctx_q.rp        <= '0;
      ctx_q.wp        <= '0;
      ctx_q.empty     <= 1'b1;
      ctx_q.full      <= 1'b0;
      ctx_q.seq       <= wqm_pkg::SEQ_IDLE;
      ctx_q.remaining <= '0;
      ctx_q.tag       <= '0;
      ctx_q.offset    <= '0;
      ctx_q.holding   <= 1'b0;
      dev_addr_q      <= wqm_pkg::DeviceAddressReset;
      out_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        dev_addr_q <= cfg_wdata_i;
      end
      if (ex_go) begin
        ctx_q       <= ctx_next;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (ex_go) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule
